### rtl/core/char_lcd_nibble_write_sequencer_defines.svh
// Assertion macros shared by the sequencer top level.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLNWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/clnws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clnws_pkg;

    // Input command codes.
    localparam logic [2:0] CMD_INSTR = 3'd0;
    localparam logic [2:0] CMD_CHAR  = 3'd1;
    localparam logic [2:0] CMD_INIT  = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_HOME  = 3'd4;
    localparam logic [2:0] CMD_CURSOR = 3'd5;

    // Fixed instructions.
    localparam logic [7:0] INSTR_CLEAR = 8'h01;
    localparam logic [7:0] INSTR_HOME  = 8'h02;

    // Wake-up nibbles of the initialization run.
    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    // Steps of one nibble.
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;

    // Final nibble index of a run.
    localparam logic [3:0] NIB_LAST_BYTE = 4'd1;
    localparam logic [3:0] NIB_LAST_INIT = 4'd11;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PULSE   = 3'd0;
    localparam logic [2:0] CFG_SETTLE  = 3'd1;
    localparam logic [2:0] CFG_FUNC    = 3'd2;
    localparam logic [2:0] CFG_DISP    = 3'd3;
    localparam logic [2:0] CFG_ENTRY   = 3'd4;
    localparam logic [2:0] CFG_LINE1   = 3'd5;
    localparam logic [2:0] CFG_LINE2   = 3'd6;
    localparam logic [2:0] CFG_LONG    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 18;

    // Controller to datapath.
    typedef struct packed {
        logic       start;
        logic       load;
        logic       lead;
        logic [3:0] nib_idx;
        logic [1:0] phase;
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_go;
        logic in_init;
        logic nib_last;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/clnws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clnws_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    input  wire clnws_pkg::t_dp_stat  i_stat,
    output clnws_pkg::t_ctrl_cmd      o_cmd
);
    import clnws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEAD,
        S_RUN
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_nib, n_nib;
    logic [1:0] r_phase, n_phase;
    logic       r_valid, n_valid;
    logic       w_accept;
    logic       w_load;
    logic       w_last_step;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_valid;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_load      = (r_state != S_IDLE) && (!r_valid || i_m_tready);
    assign w_last_step = (r_state == S_RUN) && i_stat.nib_last && (r_phase == PH_SETTLE);

    assign o_cmd.start   = w_accept;
    assign o_cmd.load    = w_load;
    assign o_cmd.lead    = (r_state == S_LEAD);
    assign o_cmd.nib_idx = r_nib;
    assign o_cmd.phase   = r_phase;

    // Next state: walk the nibbles, three steps each, one step per output slot.
    always_comb begin
        n_state = r_state;
        n_nib   = r_nib;
        n_phase = r_phase;
        n_valid = r_valid;
        if (r_valid && i_m_tready) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                n_nib   = 4'd0;
                n_phase = PH_SETUP;
                if (w_accept && i_stat.in_go) begin
                    n_state = i_stat.in_init ? S_LEAD : S_RUN;
                end
            end
            S_LEAD: begin
                if (w_load) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_load) begin
                    if (w_last_step) begin
                        n_state = S_IDLE;
                    end else if (r_phase == PH_SETTLE) begin
                        n_phase = PH_SETUP;
                        n_nib   = r_nib + 4'd1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nib   <= 4'd0;
            r_phase <= PH_SETUP;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nib   <= n_nib;
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/clnws_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module clnws_dp #(
    parameter int POWER_ON_WAIT_US    = 40000,
    parameter int INIT_FIRST_WAIT_US  = 5000,
    parameter int INIT_SECOND_WAIT_US = 150000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [clnws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [clnws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [2:0]                        i_command,
    input  wire logic [7:0]                        i_byte_value,
    input  wire logic [1:0]                        i_row,
    input  wire logic [5:0]                        i_column,
    input  wire clnws_pkg::t_ctrl_cmd              i_cmd,
    output clnws_pkg::t_dp_stat                    o_stat,
    output logic                                   o_reg_select,
    output logic                                   o_read_write,
    output logic                                   o_enable,
    output logic [3:0]                             o_data_nibble,
    output logic [clnws_pkg::HOLD_W-1:0]           o_hold_us,
    output logic                                   o_last
);
    import clnws_pkg::*;

    // Configuration registers.
    logic [9:0]  r_pulse;
    logic [13:0] r_settle;
    logic [7:0]  r_func, r_disp, r_entry, r_line1, r_line2;
    logic [15:0] r_long;

    // Latched item.
    logic [2:0] r_command;
    logic [7:0] r_byte;
    logic [1:0] r_row;
    logic [5:0] r_column;

    // Output payload.
    logic              r_rs, r_en, r_last;
    logic [3:0]        r_nibble;
    logic [HOLD_W-1:0] r_hold;

    logic              w_init;
    logic [7:0]        w_addr;
    logic [7:0]        w_byte;
    logic [3:0]        w_nib;
    logic [HOLD_W-1:0] w_extra;
    logic              w_rs, w_en, w_last;
    logic [3:0]        w_step_nib;
    logic [HOLD_W-1:0] w_hold;

    // Configuration writes; every index in range names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse  <= 10'd10;
            r_settle <= 14'd100;
            r_func   <= 8'h28;
            r_disp   <= 8'h0E;
            r_entry  <= 8'h06;
            r_line1  <= 8'h80;
            r_line2  <= 8'hC0;
            r_long   <= 16'd2000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PULSE:  r_pulse  <= i_cfg_data[9:0];
                CFG_SETTLE: r_settle <= i_cfg_data[13:0];
                CFG_FUNC:   r_func   <= i_cfg_data[7:0];
                CFG_DISP:   r_disp   <= i_cfg_data[7:0];
                CFG_ENTRY:  r_entry  <= i_cfg_data[7:0];
                CFG_LINE1:  r_line1  <= i_cfg_data[7:0];
                CFG_LINE2:  r_line2  <= i_cfg_data[7:0];
                CFG_LONG:   r_long   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Decode of the offered item: which commands produce a run at all.
    assign o_stat.in_go = (i_command <= CMD_HOME) ||
                          ((i_command == CMD_CURSOR) && ((i_row == 2'd1) || (i_row == 2'd2)));
    assign o_stat.in_init = (i_command == CMD_INIT);

    // Capture the item at the input transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_command <= i_command;
            r_byte    <= i_byte_value;
            r_row     <= i_row;
            r_column  <= i_column;
        end
    end

    assign w_init = (r_command == CMD_INIT);
    assign o_stat.nib_last = w_init ? (i_cmd.nib_idx == NIB_LAST_INIT)
                                    : (i_cmd.nib_idx == NIB_LAST_BYTE);

    // Cursor address wraps modulo 256, so column zero gives all ones.
    assign w_addr = {2'b00, r_column} - 8'd1;

    // Byte of a single-byte run.
    always_comb begin
        case (r_command)
            CMD_INSTR:  w_byte = r_byte;
            CMD_CHAR:   w_byte = r_byte;
            CMD_CLEAR:  w_byte = INSTR_CLEAR;
            CMD_HOME:   w_byte = INSTR_HOME;
            CMD_CURSOR: w_byte = w_addr | ((r_row == 2'd1) ? r_line1 : r_line2);
            default:    w_byte = 8'h00;
        endcase
    end

    // Nibble value and extra settle wait for the current nibble.
    always_comb begin
        w_nib   = 4'h0;
        w_extra = '0;
        if (w_init) begin
            case (i_cmd.nib_idx)
                4'd0: begin
                    w_nib   = NIB_WAKE;
                    w_extra = HOLD_W'(INIT_FIRST_WAIT_US);
                end
                4'd1: begin
                    w_nib   = NIB_WAKE;
                    w_extra = HOLD_W'(INIT_SECOND_WAIT_US);
                end
                4'd2:  w_nib = NIB_WAKE;
                4'd3:  w_nib = NIB_4BIT;
                4'd4:  w_nib = r_func[7:4];
                4'd5:  w_nib = r_func[3:0];
                4'd6:  w_nib = r_disp[7:4];
                4'd7:  w_nib = r_disp[3:0];
                4'd8:  w_nib = INSTR_CLEAR[7:4];
                4'd9: begin
                    w_nib   = INSTR_CLEAR[3:0];
                    w_extra = HOLD_W'(r_long);
                end
                4'd10: w_nib = r_entry[7:4];
                4'd11: w_nib = r_entry[3:0];
                default: begin
                end
            endcase
        end else begin
            w_nib = i_cmd.nib_idx[0] ? w_byte[3:0] : w_byte[7:4];
            if (i_cmd.nib_idx[0] && ((r_command == CMD_CLEAR) || (r_command == CMD_HOME))) begin
                w_extra = HOLD_W'(r_long);
            end
        end
    end

    // Pin state of the current step.
    always_comb begin
        if (i_cmd.lead) begin
            w_rs       = 1'b0;
            w_en       = 1'b0;
            w_step_nib = 4'h0;
            w_hold     = HOLD_W'(POWER_ON_WAIT_US);
            w_last     = 1'b0;
        end else begin
            w_rs       = (r_command == CMD_CHAR);
            w_en       = (i_cmd.phase == PH_HIGH);
            w_step_nib = w_nib;
            w_hold     = (i_cmd.phase == PH_SETTLE) ? (HOLD_W'(r_settle) + w_extra)
                                                    : HOLD_W'(r_pulse);
            w_last     = o_stat.nib_last && (i_cmd.phase == PH_SETTLE);
        end
    end

    // Output register, loaded when the slot is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rs     <= w_rs;
            r_en     <= w_en;
            r_nibble <= w_step_nib;
            r_hold   <= w_hold;
            r_last   <= w_last;
        end
    end

    assign o_reg_select  = r_rs;
    assign o_read_write  = 1'b0;
    assign o_enable      = r_en;
    assign o_data_nibble = r_nibble;
    assign o_hold_us     = r_hold;
    assign o_last        = r_last;

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Payload
// s_axis    in         i_s_tvalid / o_s_tready   i_s_tdata: command, byte, row, column
// m_axis    out        o_m_tvalid / i_m_tready   o_m_tdata: pins and hold, o_m_tlast
// cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One pin step leaves per cycle while the sink is ready; the step counter in the
// controller sets the pace: a byte command gives 6 steps, initialization gives 37
// steps, the first a lead step. Commands that give no steps keep the input side ready.
// Reset is synchronous, active low, and restores the register defaults.
// A stalled sink holds the output register and freezes the step counter.
// The next item is taken once the final step is in the output register.

module char_lcd_nibble_write_sequencer #(
    parameter int POWER_ON_WAIT_US    = 40000,
    parameter int INIT_FIRST_WAIT_US  = 5000,
    parameter int INIT_SECOND_WAIT_US = 150000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [clnws_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [clnws_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // command[2:0], byte_value[10:3], row[12:11], column[18:13], zero[23:19]
    input  wire logic [23:0]                       i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // reg_select[0], read_write[1], enable[2], data_nibble[6:3], hold_us[24:7], zero[31:25]
    output logic [31:0]                            o_m_tdata,
    output logic                                   o_m_tlast
);
    import clnws_pkg::*;
`include "char_lcd_nibble_write_sequencer_defines.svh"

    t_ctrl_cmd         w_cmd;
    t_dp_stat          w_stat;
    logic              w_rs, w_rw, w_en;
    logic [3:0]        w_nib;
    logic [HOLD_W-1:0] w_hold;

    clnws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    clnws_dp #(
        .POWER_ON_WAIT_US    (POWER_ON_WAIT_US),
        .INIT_FIRST_WAIT_US  (INIT_FIRST_WAIT_US),
        .INIT_SECOND_WAIT_US (INIT_SECOND_WAIT_US)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_s_tdata[2:0]),
        .i_byte_value  (i_s_tdata[10:3]),
        .i_row         (i_s_tdata[12:11]),
        .i_column      (i_s_tdata[18:13]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_reg_select  (w_rs),
        .o_read_write  (w_rw),
        .o_enable      (w_en),
        .o_data_nibble (w_nib),
        .o_hold_us     (w_hold),
        .o_last        (o_m_tlast)
    );

    // Pack the pin step into the output bus.
    assign o_m_tdata = {7'd0, w_hold, w_nib, w_en, w_rw, w_rs};

    // The output register is never overwritten while its transaction is pending.
    `CLNWS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !w_cmd.load, "step overwritten while stalled")

    // Loading the final step of a run frees the input side next cycle.
    `CLNWS_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, w_cmd.load && !w_cmd.lead && w_stat.nib_last && (w_cmd.phase == PH_SETTLE), o_s_tready, "run did not end after final step")

    // A step still waiting while the input side is open must close its run.
    `CLNWS_ASSERT_IMPL(a_idle_last, i_clk, i_rst_n, o_s_tready && o_m_tvalid, o_m_tlast, "pending step in idle is not final")

endmodule

`default_nettype wire

### tb/sv/char_lcd_nibble_write_sequencer_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_tb;

    import clnws_pkg::*;

    // Timing constants of the initialization run, shared with the instance.
    localparam int ON_WAIT_US      = 40000;
    localparam int WAKE_FIRST_US   = 5000;
    localparam int WAKE_SECOND_US  = 150000;

    // Command codes that the block must ignore.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int LCD_ITEMS       = 480;
    localparam int PHASE_ITEMS     = 80;
    localparam int QUIET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int STALL_AT_RESULT = 300;
    localparam int STALL_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    // One command on the input stream; cmd sits in the lowest bits.
    typedef struct packed {
        logic [5:0] col;
        logic [1:0] row;
        logic [7:0] byte_val;
        logic [2:0] cmd;
    } t_lcd_cmd;

    // One pin state with its hold time.
    typedef struct packed {
        logic        rs;
        logic        rw;
        logic        en;
        logic [3:0]  nib;
        logic [17:0] hold;
        logic        last;
    } t_pin_step;

    // Directed row: the command plus, where typed, the byte seen on the pins.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  byte_val;
        logic [1:0]  row;
        logic [5:0]  col;
        logic        typed;
        logic        silent;
        logic        rs;
        logic [7:0]  tbyte;
        logic [15:0] textra;
    } t_dir_row;

    // How the expected run of one accepted command is to be formed.
    typedef struct packed {
        logic        typed;
        logic        silent;
        logic        rs;
        logic [7:0]  tbyte;
        logic [15:0] textra;
    } t_run_note;

    // Directed rows; all run with the register values after reset.
    localparam int DIR_ROWS = 17;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{CMD_INIT,   8'h00, 2'd0, 6'd1,  1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
        '{CMD_INSTR,  8'h00, 2'd0, 6'd1,  1'b1, 1'b0, 1'b0, 8'h00, 16'd0},
        '{CMD_INSTR,  8'hFF, 2'd3, 6'd63, 1'b1, 1'b0, 1'b0, 8'hFF, 16'd0},
        '{CMD_CHAR,   8'hFF, 2'd0, 6'd0,  1'b1, 1'b0, 1'b1, 8'hFF, 16'd0},
        '{CMD_CHAR,   8'h00, 2'd1, 6'd1,  1'b1, 1'b0, 1'b1, 8'h00, 16'd0},
        '{CMD_CHAR,   8'h5A, 2'd2, 6'd40, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
        '{CMD_CLEAR,  8'hFF, 2'd1, 6'd7,  1'b1, 1'b0, 1'b0, 8'h01, 16'd2000},
        '{CMD_HOME,   8'hA5, 2'd2, 6'd9,  1'b1, 1'b0, 1'b0, 8'h02, 16'd2000},
        '{CMD_CURSOR, 8'h00, 2'd1, 6'd1,  1'b1, 1'b0, 1'b0, 8'h80, 16'd0},
        '{CMD_CURSOR, 8'hFF, 2'd2, 6'd40, 1'b1, 1'b0, 1'b0, 8'hE7, 16'd0},
        '{CMD_CURSOR, 8'h00, 2'd1, 6'd0,  1'b1, 1'b0, 1'b0, 8'hFF, 16'd0},
        '{CMD_CURSOR, 8'h00, 2'd2, 6'd63, 1'b1, 1'b0, 1'b0, 8'hFE, 16'd0},
        '{CMD_CURSOR, 8'h00, 2'd0, 6'd5,  1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
        '{CMD_CURSOR, 8'h00, 2'd3, 6'd5,  1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
        '{CMD_SPARE6, 8'h33, 2'd1, 6'd2,  1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
        '{CMD_SPARE7, 8'hCC, 2'd2, 6'd3,  1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
        '{CMD_CURSOR, 8'h00, 2'd1, 6'd20, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // command[2:0], byte_value[10:3], row[12:11], column[18:13], zero[23:19]
    logic [23:0]           i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // reg_select[0], read_write[1], enable[2], data_nibble[6:3], hold_us[24:7], zero[31:25]
    logic [31:0]           o_m_tdata;
    logic                  o_m_tlast;

    // Shadow copy of the configuration registers.
    logic [9:0]  pulse_us   = 10'd10;
    logic [13:0] settle_us  = 14'd100;
    logic [7:0]  func_code  = 8'h28;
    logic [7:0]  disp_code  = 8'h0E;
    logic [7:0]  entry_code = 8'h06;
    logic [7:0]  line1_base = 8'h80;
    logic [7:0]  line2_base = 8'hC0;
    logic [15:0] long_us    = 16'd2000;

    t_pin_step pending_pins[$];
    t_run_note run_notes[$];
    int        mismatches = 0;
    int        quiet_count = 0;

    char_lcd_nibble_write_sequencer #(
        .POWER_ON_WAIT_US    (ON_WAIT_US),
        .INIT_FIRST_WAIT_US  (WAKE_FIRST_US),
        .INIT_SECOND_WAIT_US (WAKE_SECOND_US)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pin-step predictor.
    function automatic void push_step(logic rs, logic en, logic [3:0] nib, int hold);
        t_pin_step s;
        s.rs   = rs;
        s.rw   = 1'b0;
        s.en   = en;
        s.nib  = nib;
        s.hold = hold[17:0];
        s.last = 1'b0;
        pending_pins.push_back(s);
    endfunction

    // A nibble is data with EN low, EN high, then EN low with the settle time.
    function automatic void push_nibble(logic rs, logic [3:0] nib, int extra);
        push_step(rs, 1'b0, nib, int'(pulse_us));
        push_step(rs, 1'b1, nib, int'(pulse_us));
        push_step(rs, 1'b0, nib, int'(settle_us) + extra);
    endfunction

    function automatic void push_byte(logic rs, logic [7:0] b, int extra);
        push_nibble(rs, b[7:4], 0);
        push_nibble(rs, b[3:0], extra);
    endfunction

    function automatic void predict_pins(t_lcd_cmd c);
        logic [7:0] addr;
        // The address wraps modulo 256, so column zero gives all ones.
        addr = {2'b00, c.col} - 8'd1;
        case (c.cmd)
            CMD_INSTR: push_byte(1'b0, c.byte_val, 0);
            CMD_CHAR:  push_byte(1'b1, c.byte_val, 0);
            CMD_INIT: begin
                push_step(1'b0, 1'b0, 4'h0, ON_WAIT_US);
                push_nibble(1'b0, NIB_WAKE, WAKE_FIRST_US);
                push_nibble(1'b0, NIB_WAKE, WAKE_SECOND_US);
                push_nibble(1'b0, NIB_WAKE, 0);
                push_nibble(1'b0, NIB_4BIT, 0);
                push_byte(1'b0, func_code, 0);
                push_byte(1'b0, disp_code, 0);
                push_byte(1'b0, INSTR_CLEAR, int'(long_us));
                push_byte(1'b0, entry_code, 0);
            end
            CMD_CLEAR: push_byte(1'b0, INSTR_CLEAR, int'(long_us));
            CMD_HOME:  push_byte(1'b0, INSTR_HOME, int'(long_us));
            CMD_CURSOR: begin
                if (c.row == 2'd1) begin
                    push_byte(1'b0, addr | line1_base, 0);
                end else if (c.row == 2'd2) begin
                    push_byte(1'b0, addr | line2_base, 0);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Watch both streams and the register port at every edge.
    always @(posedge i_clk) begin
        t_run_note note;
        t_pin_step want;
        t_pin_step tail;
        int        base;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PULSE:  pulse_us   = i_cfg_data[9:0];
                    CFG_SETTLE: settle_us  = i_cfg_data[13:0];
                    CFG_FUNC:   func_code  = i_cfg_data[7:0];
                    CFG_DISP:   disp_code  = i_cfg_data[7:0];
                    CFG_ENTRY:  entry_code = i_cfg_data[7:0];
                    CFG_LINE1:  line1_base = i_cfg_data[7:0];
                    CFG_LINE2:  line2_base = i_cfg_data[7:0];
                    CFG_LONG:   long_us    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // A command transaction: queue its expected run of pin steps.
            if (i_s_tvalid && o_s_tready) begin
                note = run_notes.pop_front();
                base = pending_pins.size();
                if (!note.typed) begin
                    predict_pins(t_lcd_cmd'(i_s_tdata[18:0]));
                end else if (!note.silent) begin
                    push_byte(note.rs, note.tbyte, int'(note.textra));
                end
                if (pending_pins.size() > base) begin
                    tail = pending_pins.pop_back();
                    tail.last = 1'b1;
                    pending_pins.push_back(tail);
                end
            end
            // A pin-step transaction: compare with the oldest expectation.
            if (o_m_tvalid && i_m_tready) begin
                if (pending_pins.size() == 0) begin
                    $display("%0t ns: unexpected step expected none actual %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                    mismatches++;
                end else begin
                    want = pending_pins.pop_front();
                    check_field("reg_select", want.rs, o_m_tdata[0]);
                    check_field("read_write", want.rw, o_m_tdata[1]);
                    check_field("enable", want.en, o_m_tdata[2]);
                    check_field("data_nibble", want.nib, o_m_tdata[6:3]);
                    check_field("hold_us", want.hold, o_m_tdata[24:7]);
                    check_field("last", want.last, o_m_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("char_lcd_nibble_write_sequencer: mismatch");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Pin-step sink with random stalls, calm stretches and one long hold-off.
    initial begin
        int hold_off;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == STALL_AT_RESULT) begin
                hold_off = STALL_CYCLES;
            end else if ((taken / 70) % 3 == 1) begin
                hold_off = 0;
            end else begin
                hold_off = $urandom_range(0, 4);
            end
            if (hold_off != 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
        end
    end

    // Offer one command, after a random gap unless in a calm stretch.
    task automatic offer_cmd(input t_lcd_cmd c, input t_run_note note, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        run_notes.push_back(note);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, c};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stop offering and wait until every expected step has come back.
    task automatic drain_pins();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pins.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Write all registers once the block has gone idle.
    task automatic load_regs(input logic [15:0] pulse, input logic [15:0] settle,
                             input logic [15:0] func, input logic [15:0] disp,
                             input logic [15:0] entry, input logic [15:0] line1,
                             input logic [15:0] line2, input logic [15:0] long_wait);
        drain_pins();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        write_reg(CFG_PULSE, pulse);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_FUNC, func);
        write_reg(CFG_DISP, disp);
        write_reg(CFG_ENTRY, entry);
        write_reg(CFG_LINE1, line1);
        write_reg(CFG_LINE2, line2);
        write_reg(CFG_LONG, long_wait);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random command mix, weighted toward commands that drive the pins.
    function automatic t_lcd_cmd random_cmd();
        t_lcd_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) c.cmd = CMD_INSTR;
        else if (pick < 50) c.cmd = CMD_CHAR;
        else if (pick < 55) c.cmd = CMD_INIT;
        else if (pick < 64) c.cmd = CMD_CLEAR;
        else if (pick < 72) c.cmd = CMD_HOME;
        else if (pick < 96) c.cmd = CMD_CURSOR;
        else c.cmd = 3'($urandom_range(CMD_SPARE6, CMD_SPARE7));
        c.byte_val = 8'($urandom_range(0, 255));
        c.row = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2))
                                           : 2'($urandom_range(0, 3));
        c.col = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 40))
                                           : 6'($urandom_range(0, 63));
        return c;
    endfunction

    initial begin
        t_lcd_cmd  c;
        t_run_note note;
        int        driven;
        int        phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the register values after reset.
        for (int k = 0; k < DIR_ROWS; k++) begin
            c.cmd      = DIRECTED[k].cmd;
            c.byte_val = DIRECTED[k].byte_val;
            c.row      = DIRECTED[k].row;
            c.col      = DIRECTED[k].col;
            note = '{DIRECTED[k].typed, DIRECTED[k].silent, DIRECTED[k].rs,
                     DIRECTED[k].tbyte, DIRECTED[k].textra};
            offer_cmd(c, note, 1'b0);
        end

        // Random part, one register setting per phase.
        note = '0;
        driven = 0;
        phase = 0;
        while (driven < LCD_ITEMS) begin
            if (driven == phase * PHASE_ITEMS) begin
                case (phase)
                    0: load_regs(16'd10, 16'd100, 16'h28, 16'h0E, 16'h06, 16'h80, 16'hC0,
                                 16'd2000);
                    1: load_regs(16'd1, 16'd1, 16'h00, 16'h00, 16'h00, 16'h00, 16'h00, 16'd0);
                    2: load_regs(16'd1000, 16'd10000, 16'hFF, 16'hFF, 16'hFF, 16'hFF, 16'hFF,
                                 16'd65535);
                    4: load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                    default: load_regs(16'($urandom_range(1, 1000)),
                                       16'($urandom_range(1, 10000)),
                                       16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 65535)));
                endcase
                phase++;
            end else if (driven % PHASE_ITEMS == PHASE_ITEMS / 2) begin
                drain_pins();
            end
            c = random_cmd();
            offer_cmd(c, note, ((driven / 50) % 3) == 2);
            driven++;
        end

        drain_pins();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("char_lcd_nibble_write_sequencer: match");
        end else begin
            $display("char_lcd_nibble_write_sequencer: mismatch");
        end
        $finish;
    end

endmodule
